### rtl/efwq_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// efwq_pkg: shared definitions for the event flag waiter queue
// Operation and status codes, sequencer states and parameter defaults.
// ----------------------------------------------------------------------------
package efwq_pkg;

    localparam int MAX_WAITERS_DEF = 16;
    localparam int ID_BITS_DEF     = 8;
    localparam int ID_PORT_W       = 8;
    localparam int FUNC_W          = 3;
    localparam int STATUS_W        = 2;

    localparam logic [FUNC_W-1:0] FUNC_WAIT   = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_SET    = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_PULSE  = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_CANCEL = 3'd4;

    localparam logic [STATUS_W-1:0] ST_DONE     = 2'd0;
    localparam logic [STATUS_W-1:0] ST_BLOCKED  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL     = 2'd2;
    localparam logic [STATUS_W-1:0] ST_NOTFOUND = 2'd3;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RESP,
        S_REL,
        S_SRCH,
        S_SHFT
    } state_t;

endpackage
`default_nettype wire

### rtl/event_flag_waiter_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// event_flag_waiter_queue: event object with a FIFO of waiting task ids
// Holds an event flag and an ordered queue of waiter ids in a RAM, walked by
// a small sequencer over one read port and one write port.
//
// Input channel (in_valid/in_ready) carries func and waiter_id; output
// channel (out_valid/out_ready) carries one result per transaction, with
// last marking the final result of an operation.
// in_ready is high only while the sequencer is idle; one operation is
// processed at a time.
// Wait, clear and unused codes: one result, in the cycle after acceptance.
// Set and pulse: first result in the cycle after acceptance, then one result
// per cycle per queued waiter while the receiver is ready, oldest first, paced by the RAM read port.
// Cancel: searches the entries from the oldest, then moves each later entry
// up one slot, then gives one result.
// A stalled receiver holds the current result and freezes the sequencer.
// Reset clears the flag and empties the queue; the RAM needs no clearing.
// ----------------------------------------------------------------------------
module event_flag_waiter_queue #(
    parameter int MAX_WAITERS = efwq_pkg::MAX_WAITERS_DEF,
    parameter int ID_BITS     = efwq_pkg::ID_BITS_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    output logic                                   in_ready,
    input  wire logic [efwq_pkg::FUNC_W-1:0]       func,
    input  wire logic [efwq_pkg::ID_PORT_W-1:0]    waiter_id,
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output logic                                   woken_valid,
    output logic      [efwq_pkg::ID_PORT_W-1:0]    woken_id,
    output logic      [efwq_pkg::STATUS_W-1:0]     status,
    output logic                                   flag_set,
    output logic                                   last
);

    import efwq_pkg::*;

    localparam int AW = (MAX_WAITERS > 1) ? $clog2(MAX_WAITERS) : 1;
    localparam int CW = $clog2(MAX_WAITERS + 1);
    localparam int IW = (ID_BITS > ID_PORT_W) ? ID_BITS : ID_PORT_W;

    state_t              state_reg, state_next;
    logic [CW-1:0]       count_reg, count_next;
    logic                flag_reg, flag_next;
    logic [AW-1:0]       idx_reg, idx_next;
    logic [ID_BITS-1:0]  id_reg, id_next;
    logic [STATUS_W-1:0] status_reg, status_next;

    logic                ram_we, ram_re;
    logic [AW-1:0]       ram_waddr, ram_raddr;
    logic [ID_BITS-1:0]  ram_wdata, ram_rdata;

    logic [IW-1:0]       in_id_wide, out_id_wide;
    logic [ID_BITS-1:0]  in_id;
    logic                in_fire, out_fire, idx_last, full;
    logic [AW-1:0]       idx_inc;

    assign in_id_wide  = IW'(waiter_id);
    assign in_id       = in_id_wide[ID_BITS-1:0];
    assign out_id_wide = IW'(ram_rdata);

    assign in_fire  = in_valid && in_ready;
    assign out_fire = out_valid && out_ready;
    assign idx_last = (CW'(idx_reg) == (count_reg - CW'(1)));
    assign idx_inc  = idx_reg + AW'(1);
    assign full     = (count_reg == CW'(MAX_WAITERS));

    efwq_ram #(
        .WIDTH (ID_BITS),
        .DEPTH (MAX_WAITERS),
        .AW    (AW)
    ) u_slots (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            flag_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            flag_reg  <= flag_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg    <= idx_next;
        id_reg     <= id_next;
        status_reg <= status_next;
    end

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        flag_next   = flag_reg;
        idx_next    = idx_reg;
        id_next     = id_reg;
        status_next = status_reg;
        ram_we      = 1'b0;
        ram_waddr   = count_reg[AW-1:0];
        ram_wdata   = in_id;
        ram_re      = 1'b0;
        ram_raddr   = idx_inc;

        in_ready    = (state_reg == S_IDLE);
        out_valid   = (state_reg == S_RESP) || (state_reg == S_REL);
        woken_valid = (state_reg == S_REL);
        woken_id    = woken_valid ? out_id_wide[ID_PORT_W-1:0] : '0;
        status      = (state_reg == S_REL) ? ST_DONE : status_reg;
        flag_set    = flag_reg;
        last        = (state_reg == S_REL) ? idx_last : 1'b1;

        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    status_next = ST_DONE;
                    state_next  = S_RESP;
                    idx_next    = '0;
                    id_next     = in_id;
                    ram_raddr   = '0;
                    case (func)
                        FUNC_WAIT:
                        begin
                            if (flag_reg)
                            begin
                                status_next = ST_DONE;
                            end
                            else if (full)
                            begin
                                status_next = ST_FULL;
                            end
                            else
                            begin
                                ram_we      = 1'b1;
                                count_next  = count_reg + CW'(1);
                                status_next = ST_BLOCKED;
                            end
                        end
                        FUNC_SET, FUNC_PULSE:
                        begin
                            if (func == FUNC_SET)
                            begin
                                flag_next = 1'b1;
                            end
                            if (count_reg != '0)
                            begin
                                ram_re     = 1'b1;
                                state_next = S_REL;
                            end
                        end
                        FUNC_CLEAR:
                        begin
                            flag_next = 1'b0;
                        end
                        FUNC_CANCEL:
                        begin
                            if (count_reg != '0)
                            begin
                                ram_re     = 1'b1;
                                state_next = S_SRCH;
                            end
                            else
                            begin
                                status_next = ST_NOTFOUND;
                            end
                        end
                        default:
                        begin
                            status_next = ST_DONE;
                        end
                    endcase
                end
            end
            S_RESP:
            begin
                if (out_fire)
                begin
                    state_next = S_IDLE;
                end
            end
            S_REL:
            begin
                if (out_fire)
                begin
                    if (idx_last)
                    begin
                        count_next = '0;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        ram_re   = 1'b1;
                        idx_next = idx_inc;
                    end
                end
            end
            S_SRCH:
            begin
                if (ram_rdata == id_reg)
                begin
                    if (idx_last)
                    begin
                        count_next  = count_reg - CW'(1);
                        status_next = ST_DONE;
                        state_next  = S_RESP;
                    end
                    else
                    begin
                        ram_re     = 1'b1;
                        idx_next   = idx_inc;
                        state_next = S_SHFT;
                    end
                end
                else if (idx_last)
                begin
                    status_next = ST_NOTFOUND;
                    state_next  = S_RESP;
                end
                else
                begin
                    ram_re   = 1'b1;
                    idx_next = idx_inc;
                end
            end
            S_SHFT:
            begin
                ram_we    = 1'b1;
                ram_waddr = idx_reg - AW'(1);
                ram_wdata = ram_rdata;
                if (idx_last)
                begin
                    count_next  = count_reg - CW'(1);
                    status_next = ST_DONE;
                    state_next  = S_RESP;
                end
                else
                begin
                    ram_re   = 1'b1;
                    idx_next = idx_inc;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    a_idle_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> !out_valid)
        else $error("input accepted while a result is pending");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(MAX_WAITERS))
        else $error("waiter count beyond queue depth");

    a_release_empties: assert property (@(posedge clk) disable iff (!rst_n)
        (out_fire && woken_valid && last) |=> (count_reg == '0))
        else $error("queue not empty after final wakeup");

    a_wake_status: assert property (@(posedge clk) disable iff (!rst_n)
        woken_valid |-> (status == ST_DONE && count_reg != '0))
        else $error("wakeup without a queued waiter");

endmodule
`default_nettype wire

### rtl/efwq_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// efwq_ram: generic single write, single read RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module efwq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire
